// ----- hw/rtl/dmsrc_pkg.sv -----
`default_nettype none

package dmsrc_pkg;

    // Sizes fixed by the field widths
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 24;
    localparam int OFFS_W      = 15;
    localparam int BIDX_W      = 6;
    localparam int TAG_BITS    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SPAN_W      = 25;
    localparam int REMAIN_W    = 7;

    // Default for the top-level parameter
    localparam int MAX_BLOCKS_DEF = 64;

    // Tag value of a block that holds nothing
    localparam logic [TAG_BITS-1:0] TAG_EMPTY = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ON    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LOG2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA       = 2'd3;

    // Configuration reset values
    localparam logic       RST_CACHE_ON   = 1'b1;
    localparam logic [3:0] RST_SIZE_LOG2  = 4'd9;
    localparam logic [2:0] RST_COUNT_LOG2 = 3'd4;
    localparam logic [5:0] RST_EXTRA      = 6'd0;
    localparam logic [2:0] COUNT_LOG2_MAX = 3'd6;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHECK,
        ST_SEND
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic read;
        logic check;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic go_cache;
        logic last;
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dmsrc_ctrl.sv -----
`default_nettype none

module dmsrc_ctrl
    import dmsrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = sts.go_cache ? ST_READ : ST_SEND;
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!out_stall)
                begin
                    state_next = sts.last ? ST_IDLE : ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                // Start the next block's tag read as this transfer completes
                cmd.read  = !out_stall && !sts.last;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !in_stall))
        else $error("input open while a result is pending");

    a_next_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && !out_stall && !sts.last) |=> (state_reg == ST_CHECK))
        else $error("span walk stopped before last block");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && !out_stall && sts.last) |=> (state_reg == ST_IDLE))
        else $error("request did not finish on last transfer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/dmsrc_dp.sv -----
`default_nettype none

module dmsrc_dp
    import dmsrc_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [ADDR_W-1:0]     read_address,
    input  wire logic [LEN_W-1:0]      read_length,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    output logic                       bypass,
    output logic                       fill,
    output logic [BIDX_W-1:0]          block_index,
    output logic [ADDR_W-1:0]          fetch_address,
    output logic [LEN_W-1:0]           fetch_length,
    output logic [OFFS_W-1:0]          start_offset,
    output logic                       last
);

    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [REMAIN_W-1:0] MAXB = REMAIN_W'(MAX_BLOCKS);

    // Configuration
    logic       cache_on_reg;
    logic [3:0] size_log2_reg;
    logic [2:0] count_log2_reg;
    logic [5:0] extra_reg;

    // Request and walk registers
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [OFFS_W-1:0]   offs_reg;
    logic [BIDX_W-1:0]   blk_reg;
    logic [REMAIN_W-1:0] remain_reg;
    logic [TAG_BITS-1:0] tag_reg;

    // Tag store with per-block valid bits
    logic [TAG_BITS-1:0] tag_mem [MAX_BLOCKS];
    logic                vld_reg [MAX_BLOCKS];
    logic [TAG_BITS-1:0] rd_tag_reg;
    logic                rd_vld_reg;

    // Result register
    logic                bypass_reg;
    logic                fill_reg;
    logic [BIDX_W-1:0]   bidx_reg;
    logic [ADDR_W-1:0]   faddr_reg;
    logic [LEN_W-1:0]    flen_reg;
    logic [OFFS_W-1:0]   soff_reg;
    logic                last_reg;

    // Decode signals
    logic [2:0]          cnt_log2;
    logic [4:0]          cs;
    logic [OFFS_W-1:0]   mask;
    logic [OFFS_W-1:0]   offset;
    logic [ADDR_W-1:0]   addr_shr;
    logic [BIDX_W-1:0]   index;
    logic [SPAN_W-1:0]   span_sum;
    logic [SPAN_W-1:0]   span;
    logic [REMAIN_W-1:0] total_raw;
    logic [REMAIN_W-1:0] total;
    logic                fits;
    logic                len_zero;
    logic [TAG_BITS-1:0] tag_dec;
    logic [ADDR_W-1:0]   tag_shl;

    // Check signals
    logic [BLK_W-1:0]    mem_addr;
    logic [TAG_BITS-1:0] cur_tag;
    logic                miss;
    logic [ADDR_W-1:0]   fill_addr;
    logic [LEN_W-1:0]    blk_bytes;

    // Split the request address and size the span
    always_comb
    begin
        cnt_log2  = (count_log2_reg > COUNT_LOG2_MAX) ? COUNT_LOG2_MAX : count_log2_reg;
        cs        = {1'b0, size_log2_reg} + {2'b0, cnt_log2};
        mask      = ~({OFFS_W{1'b1}} << size_log2_reg);
        offset    = addr_reg[OFFS_W-1:0] & mask;
        addr_shr  = addr_reg >> size_log2_reg;
        index     = addr_shr[BIDX_W-1:0] & ~({BIDX_W{1'b1}} << cnt_log2);
        span_sum  = {10'b0, offset} + {1'b0, len_reg} + {10'b0, mask};
        span      = span_sum >> size_log2_reg;
        total_raw = (REMAIN_W'(1) << cnt_log2) + {1'b0, extra_reg};
        total     = (total_raw > MAXB) ? MAXB : total_raw;
        fits      = ({20'b0, index} + {1'b0, span}) <= {19'b0, total};
        len_zero  = (len_reg == '0);
        tag_shl   = addr_reg >> cs;
        tag_dec   = tag_shl[TAG_BITS-1:0];
    end

    // Compare one block's stored tag and form its fill address
    always_comb
    begin
        mem_addr  = blk_reg[BLK_W-1:0];
        cur_tag   = rd_vld_reg ? rd_tag_reg : TAG_EMPTY;
        miss      = (cur_tag != tag_reg);
        fill_addr = ({26'b0, blk_reg} << size_log2_reg) + ({24'b0, tag_reg} << cs);
        blk_bytes = LEN_W'(1) << size_log2_reg;
    end

    assign sts.go_cache = cache_on_reg && !len_zero && fits;
    assign sts.last     = last_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_on_reg   <= RST_CACHE_ON;
            size_log2_reg  <= RST_SIZE_LOG2;
            count_log2_reg <= RST_COUNT_LOG2;
            extra_reg      <= RST_EXTRA;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CACHE_ON:   cache_on_reg   <= cfg_data[0];
                CFG_SIZE_LOG2:  size_log2_reg  <= cfg_data[3:0];
                CFG_COUNT_LOG2: count_log2_reg <= cfg_data[2:0];
                CFG_EXTRA:      extra_reg      <= cfg_data[5:0];
                default:        cache_on_reg   <= cache_on_reg;
            endcase
        end
    end

    // Capture the request, decode it, then advance through the span
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= read_address;
            len_reg  <= read_length;
        end
        if (cmd.decode)
        begin
            offs_reg   <= offset;
            blk_reg    <= index;
            remain_reg <= span[REMAIN_W-1:0];
            tag_reg    <= tag_dec;
        end
        else if (cmd.check)
        begin
            blk_reg    <= blk_reg + BIDX_W'(1);
            remain_reg <= remain_reg - REMAIN_W'(1);
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.decode && !sts.go_cache)
        begin
            if (cache_on_reg && len_zero)
            begin
                bypass_reg <= 1'b0;
                fill_reg   <= 1'b0;
                bidx_reg   <= index;
                faddr_reg  <= '0;
                flen_reg   <= '0;
                soff_reg   <= offset;
            end
            else
            begin
                bypass_reg <= 1'b1;
                fill_reg   <= 1'b0;
                bidx_reg   <= '0;
                faddr_reg  <= addr_reg;
                flen_reg   <= len_reg;
                soff_reg   <= '0;
            end
            last_reg <= 1'b1;
        end
        else if (cmd.check)
        begin
            bypass_reg <= 1'b0;
            fill_reg   <= miss;
            bidx_reg   <= blk_reg;
            faddr_reg  <= miss ? fill_addr : '0;
            flen_reg   <= miss ? blk_bytes : '0;
            soff_reg   <= offs_reg;
            last_reg   <= (remain_reg == REMAIN_W'(1));
        end
    end

    // Tag memory: registered read, write on a fill
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_tag_reg <= tag_mem[mem_addr];
        end
        if (cmd.check && miss)
        begin
            tag_mem[mem_addr] <= tag_reg;
        end
    end

    // Valid bits: an unwritten block reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.read)
            begin
                rd_vld_reg <= vld_reg[mem_addr];
            end
            if (cmd.check && miss)
            begin
                vld_reg[mem_addr] <= 1'b1;
            end
        end
    end

    assign bypass        = bypass_reg;
    assign fill          = fill_reg;
    assign block_index   = bidx_reg;
    assign fetch_address = faddr_reg;
    assign fetch_length  = flen_reg;
    assign start_offset  = soff_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |-> ({1'b0, blk_reg} < MAXB))
        else $error("span walk left the tag store");

    a_check_cached: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |=> !bypass_reg)
        else $error("cached block marked as bypass");

    a_last_block: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && remain_reg == REMAIN_W'(1)) |=> last_reg)
        else $error("final block not marked last");

    a_fill_stores: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && miss) |=> vld_reg[$past(mem_addr)])
        else $error("fill did not mark block valid");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/direct_mapped_span_read_cache_top.sv -----
// Sequence: a cached request passes through decode, tag-store read and tag compare before
//   its first result; a bypass or zero-length request goes from decode straight to its result.
// Requests: one at a time; each further spanned block's registered tag-store read starts as the
//   previous result is taken, followed by the tag compare. An output stall holds the walk.
// Reset: asynchronous, active low; configuration returns to its defaults and all
//   block tags read as empty (255) through per-block valid bits, with no clearing pass.
`default_nettype none

module direct_mapped_span_read_cache_top
    import dmsrc_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ADDR_W-1:0]     read_address,
    input  wire logic [LEN_W-1:0]      read_length,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       bypass,
    output logic                       fill,
    output logic [BIDX_W-1:0]          block_index,
    output logic [ADDR_W-1:0]          fetch_address,
    output logic [LEN_W-1:0]           fetch_length,
    output logic [OFFS_W-1:0]          start_offset,
    output logic                       last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequence each request
    dmsrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Decode, tag store and result register
    dmsrc_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .read_address  (read_address),
        .read_length   (read_length),
        .cmd           (cmd),
        .sts           (sts),
        .bypass        (bypass),
        .fill          (fill),
        .block_index   (block_index),
        .fetch_address (fetch_address),
        .fetch_length  (fetch_length),
        .start_offset  (start_offset),
        .last          (last)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
    import dmsrc_pkg::*;

    // Kinds of random read request
    typedef enum {
        REQ_FIT,
        REQ_ZERO,
        REQ_OVERFLOW,
        REQ_NOISE
    } req_kind_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } read_req_t;

    typedef struct {
        logic              bypass;
        logic              fill;
        logic [BIDX_W-1:0] block_index;
        logic [ADDR_W-1:0] fetch_address;
        logic [LEN_W-1:0]  fetch_length;
        logic [OFFS_W-1:0] start_offset;
        logic              last;
    } lookup_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [ADDR_W-1:0]     read_address = '0;
    logic [LEN_W-1:0]      read_length = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  bypass;
    logic                  fill;
    logic [BIDX_W-1:0]     block_index;
    logic [ADDR_W-1:0]     fetch_address;
    logic [LEN_W-1:0]      fetch_length;
    logic [OFFS_W-1:0]     start_offset;
    logic                  last;

    // Shadow copy of the tag store and the configuration
    logic [TAG_BITS-1:0]   tag_shadow [MAX_BLOCKS_DEF];
    logic                  cfg_cache_on = RST_CACHE_ON;
    logic [3:0]            cfg_size_log2 = RST_SIZE_LOG2;
    logic [2:0]            cfg_count_log2 = RST_COUNT_LOG2;
    logic [5:0]            cfg_extra = RST_EXTRA;

    read_req_t             pending_reqs [$];
    lookup_result_t        lookup_expect [$];
    read_req_t             next_req;
    lookup_result_t        got_result;
    lookup_result_t        want_result;
    int                    error_count = 0;
    int                    send_gap = 0;
    int                    stall_left = 0;
    int                    hold_left = 0;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    logic                  calm = 1'b0;

    direct_mapped_span_read_cache_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .read_address (read_address),
        .read_length  (read_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bypass       (bypass),
        .fill         (fill),
        .block_index  (block_index),
        .fetch_address(fetch_address),
        .fetch_length (fetch_length),
        .start_offset (start_offset),
        .last         (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < MAX_BLOCKS_DEF; i++)
            tag_shadow[i] = TAG_EMPTY;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic lookup_result_t make_result(input logic byp, input logic fil,
                                                   input logic [63:0] blk,
                                                   input logic [63:0] faddr,
                                                   input logic [63:0] flen,
                                                   input logic [63:0] offs,
                                                   input logic lst);
        lookup_result_t r;
        r.bypass        = byp;
        r.fill          = fil;
        r.block_index   = blk[BIDX_W-1:0];
        r.fetch_address = faddr[ADDR_W-1:0];
        r.fetch_length  = flen[LEN_W-1:0];
        r.start_offset  = offs[OFFS_W-1:0];
        r.last          = lst;
        return r;
    endfunction

    // Work out the results of one accepted read request and update the tag shadow
    task automatic predict_lookup(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        int unsigned s;
        int unsigned c;
        logic [63:0] a64;
        logic [63:0] l64;
        logic [63:0] mask;
        logic [63:0] offset;
        logic [63:0] index;
        logic [63:0] span;
        logic [63:0] total;
        logic [63:0] tag;
        logic [63:0] blk;
        logic [63:0] faddr;
        a64 = {32'd0, addr};
        l64 = {40'd0, len};
        s = cfg_size_log2;
        c = (cfg_count_log2 > COUNT_LOG2_MAX) ? COUNT_LOG2_MAX : cfg_count_log2;
        mask = (64'd1 << s) - 64'd1;
        if (!cfg_cache_on)
        begin
            lookup_expect.push_back(make_result(1'b1, 1'b0, 0, a64, l64, 0, 1'b1));
            return;
        end
        offset = a64 & mask;
        index = (a64 >> s) & ((64'd1 << c) - 64'd1);
        span = (offset + l64 + mask) >> s;
        total = (64'd1 << c) + cfg_extra;
        if (total > MAX_BLOCKS_DEF)
            total = MAX_BLOCKS_DEF;
        // zero length: a single no-fill result for the start block
        if (len == '0)
        begin
            lookup_expect.push_back(make_result(1'b0, 1'b0, index, 0, 0, offset, 1'b1));
            return;
        end
        if (index + span > total)
        begin
            lookup_expect.push_back(make_result(1'b1, 1'b0, 0, a64, l64, 0, 1'b1));
            return;
        end
        tag = (a64 >> (s + c)) & 64'hFF;
        for (logic [63:0] k = 0; k < span; k++)
        begin
            blk = index + k;
            if (tag_shadow[blk] != tag[TAG_BITS-1:0])
            begin
                faddr = (blk << s) + (tag << (s + c));
                tag_shadow[blk] = tag[TAG_BITS-1:0];
                lookup_expect.push_back(make_result(1'b0, 1'b1, blk, faddr, 64'd1 << s,
                                                    offset, k + 1 == span));
            end
            else
                lookup_expect.push_back(make_result(1'b0, 1'b0, blk, 0, 0, offset,
                                                    k + 1 == span));
        end
    endtask

    // Sender: present queued requests, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            read_address <= '0;
            read_length <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_lookup(read_address, read_length);
            // advance only once the current transfer is done
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && pending_reqs.size() > 0 && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    read_address <= next_req.addr;
                    read_length <= next_req.len;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transfer, stall in bursts and on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_result.bypass        = bypass;
                got_result.fill          = fill;
                got_result.block_index   = block_index;
                got_result.fetch_address = fetch_address;
                got_result.fetch_length  = fetch_length;
                got_result.start_offset  = start_offset;
                got_result.last          = last;
                if (lookup_expect.size() == 0)
                    report_error($sformatf("unexpected result: block %0d address %h",
                                           block_index, fetch_address));
                else
                begin
                    want_result = lookup_expect.pop_front();
                    if (got_result.bypass !== want_result.bypass)
                        report_error($sformatf("bypass got %b expected %b",
                                               got_result.bypass, want_result.bypass));
                    if (got_result.fill !== want_result.fill)
                        report_error($sformatf("fill got %b expected %b",
                                               got_result.fill, want_result.fill));
                    if (got_result.block_index !== want_result.block_index)
                        report_error($sformatf("block_index got %0d expected %0d",
                                               got_result.block_index,
                                               want_result.block_index));
                    if (got_result.fetch_address !== want_result.fetch_address)
                        report_error($sformatf("fetch_address got %h expected %h",
                                               got_result.fetch_address,
                                               want_result.fetch_address));
                    if (got_result.fetch_length !== want_result.fetch_length)
                        report_error($sformatf("fetch_length got %h expected %h",
                                               got_result.fetch_length,
                                               want_result.fetch_length));
                    if (got_result.start_offset !== want_result.start_offset)
                        report_error($sformatf("start_offset got %h expected %h",
                                               got_result.start_offset,
                                               want_result.start_offset));
                    if (got_result.last !== want_result.last)
                        report_error($sformatf("last got %b expected %b",
                                               got_result.last, want_result.last));
                end
            end
            // long hold-off first, then random bursts
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_served < hold_requests)
            begin
                hold_served++;
                hold_left = 249;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic push_req(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        read_req_t r;
        r.addr = addr;
        r.len = len;
        pending_reqs.push_back(r);
    endtask

    // Mostly requests that fit the cache over a few pages, plus zero-length,
    // overflowing and fully random ones
    task automatic push_random(input int count);
        int unsigned s;
        int unsigned c;
        int unsigned total;
        int unsigned idx;
        int unsigned room;
        int unsigned spn;
        int unsigned pg;
        int unsigned roll;
        logic [63:0] blk_bytes;
        logic [63:0] off;
        logic [63:0] a64;
        logic [LEN_W-1:0] len;
        req_kind_t kind;
        repeat (count)
        begin
            s = cfg_size_log2;
            c = (cfg_count_log2 > COUNT_LOG2_MAX) ? COUNT_LOG2_MAX : cfg_count_log2;
            total = (1 << c) + cfg_extra;
            if (total > MAX_BLOCKS_DEF)
                total = MAX_BLOCKS_DEF;
            blk_bytes = 64'd1 << s;
            idx = $urandom_range(0, (1 << c) - 1);
            room = total - idx;
            off = {32'd0, $urandom} & (blk_bytes - 64'd1);
            roll = $urandom_range(0, 9);
            if (roll < 6)
                pg = $urandom_range(0, 3);
            else if (roll == 6)
                pg = TAG_EMPTY;
            else
                pg = $urandom_range(0, 255);
            a64 = ({32'd0, $urandom} << (s + c + TAG_BITS)) | ({32'd0, pg} << (s + c))
                  | ({32'd0, idx} << s) | off;
            roll = $urandom_range(0, 99);
            if (roll < 74)
                kind = REQ_FIT;
            else if (roll < 82)
                kind = REQ_ZERO;
            else if (roll < 92)
                kind = REQ_OVERFLOW;
            else
                kind = REQ_NOISE;
            case (kind)
                REQ_FIT:
                begin
                    if ($urandom_range(0, 9) == 0)
                        spn = $urandom_range(1, room);
                    else
                        spn = $urandom_range(1, (room < 4) ? room : 4);
                    len = $urandom_range(1, spn * blk_bytes - off);
                end
                REQ_ZERO:
                    len = '0;
                REQ_OVERFLOW:
                    len = room * blk_bytes - off + $urandom_range(1, blk_bytes);
                default:
                begin
                    a64 = {32'd0, $urandom};
                    len = $urandom >> $urandom_range(8, 31);
                end
            endcase
            push_req(a64[ADDR_W-1:0], len);
        end
    endtask

    // Wait until every request is sent and every result has come, then let
    // the block settle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || lookup_expect.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CACHE_ON:   cfg_cache_on = val[0];
            CFG_SIZE_LOG2:  cfg_size_log2 = val[3:0];
            CFG_COUNT_LOG2: cfg_count_log2 = val[2:0];
            default:        cfg_extra = val[5:0];
        endcase
    endtask

    task automatic set_config(input logic on, input logic [3:0] size_log2,
                              input logic [2:0] count_log2, input logic [5:0] extra);
        wait_drained();
        write_reg(CFG_CACHE_ON, {5'd0, on});
        write_reg(CFG_SIZE_LOG2, {2'd0, size_log2});
        write_reg(CFG_COUNT_LOG2, {3'd0, count_log2});
        write_reg(CFG_EXTRA, extra);
        @(negedge clk);
    endtask

    // Stimulus and end of run
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part under the reset configuration: 512-byte blocks, 16 of them
        push_req(32'h0000_0000, 24'd0);          // zero length
        push_req(32'h0000_1FFF, 24'd0);          // zero length on the last byte of the top block
        push_req(32'h0000_1E00, 24'd513);        // runs past the last block: bypass
        push_req(32'h0000_1C00, 24'd1024);       // exact fit at the top: two fills
        push_req(32'h0000_1C00, 24'd1024);       // same again: two hits
        push_req(32'h001F_E600, 24'd1);          // page 255 hits an empty block
        push_req(32'h0020_2800, 24'd10);         // page 257 aliases page 1: fill
        push_req(32'h0000_2800, 24'd10);         // page 1: hit
        push_req(32'h0000_0000, 24'd8192);       // every block of the page
        push_req(32'h0000_0001, 24'hFF_FFFF);    // longest request: bypass
        push_req(32'hFFFF_FFFF, 24'hFF_FFFF);
        push_req(32'hFFFF_FFFF, 24'd1);          // last byte of the top block
        push_req(32'hFFFF_FFFF, 24'd0);
        push_req(32'h0000_01FF, 24'd2);          // straddles blocks 0 and 1
        push_req(32'hAAAA_AAAA, 24'h55_5555);
        push_req(32'h5555_5555, 24'hAA_AAAA);
        push_req(32'h5555_5555, 24'd1);
        push_req(32'hAAAA_AAAA, 24'd1);
        wait_drained();

        // hold off the receiver while requests keep coming
        hold_requests++;
        push_random(60);

        set_config(1'b1, 4'd0, 3'd0, 6'd63);
        push_random(50);
        set_config(1'b1, 4'd15, 3'd6, 6'd63);
        push_random(50);
        set_config(1'b1, 4'd4, 3'd7, 6'd5);
        push_random(50);
        set_config(1'b0, 4'd4, 3'd7, 6'd5);
        push_random(30);
        set_config(1'b1, 4'd3, 3'd2, 6'd10);
        push_random(25);
        // pause the sender until everything has come back
        wait_drained();
        push_random(25);

        set_config(RST_CACHE_ON, RST_SIZE_LOG2, RST_COUNT_LOG2, RST_EXTRA);
        calm = 1'b1;
        push_random(60);

        wait_drained();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (lookup_expect.size() != 0)
            report_error($sformatf("%0d results never arrived", lookup_expect.size()));
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
